[sv/lpfp_pkg.sv]
// shared constants and codes for the length-prefixed frame parser
package lpfp_pkg;

  localparam int unsigned HDR_LEN   = 3;
  localparam int unsigned CNT_W     = 10;
  localparam int unsigned COUNT_MAX = (1 << CNT_W) - 1;

  typedef enum logic [2:0] {
    CLS_TYPE    = 3'd0,
    CLS_ID_LEN  = 3'd1,
    CLS_PAY_LEN = 3'd2,
    CLS_ID      = 3'd3,
    CLS_PAYLOAD = 3'd4,
    CLS_EXCESS  = 3'd5
  } byte_class_t;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_TOO_SHORT = 2'd1,
    ST_LEN_BAD   = 2'd2
  } frame_status_t;

endpackage

[sv/length_prefixed_frame_parser.sv]
// top level of the length-prefixed frame parser
// an accepted item waits in the input register, then moves on to the result register
// throughput: one item per clock while the output is not stalled; the input register doubles
//   as a skid stage, so an item is still taken while a finished result waits at the output
// per-item work is one 10-bit count compare/subtract pass against the captured header
// reset (rst_n low, synchronous) clears both valid bits, the byte count and the header fields
module length_prefixed_frame_parser (
  input  logic       clk,
  input  logic       rst_n,
  // input channel
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] in_byte,
  input  logic       in_last,
  // result channel
  output logic       out_valid,
  input  logic       out_stall,
  output logic [7:0] out_byte_value,
  output logic [2:0] out_byte_class,
  output logic [7:0] out_field_index,
  output logic [7:0] out_conn_type,
  output logic [7:0] out_id_length,
  output logic [7:0] out_payload_length,
  output logic       out_frame_end,
  output logic [1:0] out_frame_status
);

  localparam int unsigned CW = lpfp_pkg::CNT_W;

  // input register (also holds an item while the result side is stalled)
  logic       in_vld_r;
  logic [7:0] in_byte_r;
  logic       in_last_r;

  // frame state
  logic [CW-1:0] byte_count_r, byte_count_nxt;
  logic [7:0]    type_r, type_nxt;
  logic [7:0]    id_len_r, id_len_nxt;
  logic [7:0]    pay_len_r, pay_len_nxt;

  // result register
  logic       out_vld_r;
  logic [7:0] byte_value_r;
  logic [2:0] byte_class_r;
  logic [7:0] field_index_r;
  logic [7:0] conn_type_r;
  logic [7:0] id_length_r;
  logic [7:0] payload_length_r;
  logic       frame_end_r;
  logic [1:0] frame_status_r;

  // per-item results
  lpfp_pkg::byte_class_t   cls;
  lpfp_pkg::frame_status_t status;
  logic [7:0]    idx;
  logic [7:0]    type_cur, id_cur, pay_cur;
  logic [CW-1:0] id_end, pay_end;
  logic [CW-1:0] off_id, off_pay;
  logic [CW:0]   total, declared;

  logic adv;     // item in the input register moves to the result register
  logic in_acc;

  assign adv    = in_vld_r && (!out_vld_r || !out_stall);
  assign in_acc = in_valid && !in_stall;
  // the input register frees up in the same cycle that it drains
  assign in_stall = in_vld_r && !adv;

  // header capture, including the byte at hand
  always_comb begin
    type_cur = type_r;
    id_cur   = id_len_r;
    pay_cur  = pay_len_r;
    if (byte_count_r == CW'(0)) begin
      type_cur = in_byte_r;
    end
    if (byte_count_r == CW'(1)) begin
      id_cur = in_byte_r;
    end
    if (byte_count_r == CW'(2)) begin
      pay_cur = in_byte_r;
    end
  end

  // field boundaries; at most 3 + 255 + 255, so they fit the count width
  assign id_end  = CW'(lpfp_pkg::HDR_LEN) + CW'(id_len_r);
  assign pay_end = id_end + CW'(pay_len_r);
  assign off_id  = byte_count_r - CW'(lpfp_pkg::HDR_LEN);
  assign off_pay = byte_count_r - id_end;

  // byte classification
  always_comb begin
    idx = 8'd0;
    case (byte_count_r)
      CW'(0): cls = lpfp_pkg::CLS_TYPE;
      CW'(1): cls = lpfp_pkg::CLS_ID_LEN;
      CW'(2): cls = lpfp_pkg::CLS_PAY_LEN;
      default: begin
        if (byte_count_r < id_end) begin
          cls = lpfp_pkg::CLS_ID;
          idx = off_id[7:0];
        end else if (byte_count_r < pay_end) begin
          cls = lpfp_pkg::CLS_PAYLOAD;
          idx = off_pay[7:0];
        end else begin
          cls = lpfp_pkg::CLS_EXCESS;
        end
      end
    endcase
  end

  // end-of-buffer check; the total is one past the current position
  assign total    = {1'b0, byte_count_r} + (CW+1)'(1);
  assign declared = (CW+1)'(lpfp_pkg::HDR_LEN) + (CW+1)'(id_cur) + (CW+1)'(pay_cur);

  always_comb begin
    status = lpfp_pkg::ST_OK;
    if (in_last_r) begin
      if (total < (CW+1)'(lpfp_pkg::HDR_LEN)) begin
        status = lpfp_pkg::ST_TOO_SHORT;
      end else if (total != declared) begin
        status = lpfp_pkg::ST_LEN_BAD;
      end
    end
  end

  // next frame state: cleared after the last byte, count saturates otherwise
  always_comb begin
    byte_count_nxt = byte_count_r;
    type_nxt       = type_cur;
    id_len_nxt     = id_cur;
    pay_len_nxt    = pay_cur;
    if (in_last_r) begin
      byte_count_nxt = '0;
      type_nxt       = 8'd0;
      id_len_nxt     = 8'd0;
      pay_len_nxt    = 8'd0;
    end else if (byte_count_r != CW'(lpfp_pkg::COUNT_MAX)) begin
      byte_count_nxt = byte_count_r + CW'(1);
    end
  end

  // input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else begin
      if (in_acc) begin
        in_vld_r <= 1'b1;
      end else if (adv) begin
        in_vld_r <= 1'b0;
      end
    end
    if (in_acc) begin
      in_byte_r <= in_byte;
      in_last_r <= in_last;
    end
  end

  // frame state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      byte_count_r <= '0;
      type_r       <= 8'd0;
      id_len_r     <= 8'd0;
      pay_len_r    <= 8'd0;
    end else if (adv) begin
      byte_count_r <= byte_count_nxt;
      type_r       <= type_nxt;
      id_len_r     <= id_len_nxt;
      pay_len_r    <= pay_len_nxt;
    end
  end

  // result register; holds while stalled
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (adv) begin
      out_vld_r <= 1'b1;
    end else if (!out_stall) begin
      out_vld_r <= 1'b0;
    end
    if (adv) begin
      byte_value_r     <= in_byte_r;
      byte_class_r     <= cls;
      field_index_r    <= idx;
      conn_type_r      <= type_cur;
      id_length_r      <= id_cur;
      payload_length_r <= pay_cur;
      frame_end_r      <= in_last_r;
      frame_status_r   <= status;
    end
  end

  assign out_valid          = out_vld_r;
  assign out_byte_value     = byte_value_r;
  assign out_byte_class     = byte_class_r;
  assign out_field_index    = field_index_r;
  assign out_conn_type      = conn_type_r;
  assign out_id_length      = id_length_r;
  assign out_payload_length = payload_length_r;
  assign out_frame_end      = frame_end_r;
  assign out_frame_status   = frame_status_r;

`ifndef SYNTH
  // status is only non-ok on the closing item
  a_status_only_at_end: assert property (@(posedge clk) disable iff (!rst_n)
    out_vld_r && !frame_end_r |-> frame_status_r == lpfp_pkg::ST_OK)
    else $error("non-ok status on an item that does not end the frame");

  // a buffer ending on its first byte is always too short
  a_one_byte_short: assert property (@(posedge clk) disable iff (!rst_n)
    out_vld_r && frame_end_r && byte_class_r == lpfp_pkg::CLS_TYPE
    |-> frame_status_r == lpfp_pkg::ST_TOO_SHORT)
    else $error("single-byte buffer not flagged too short");

  // ending on an excess byte means the total overran the declared length
  a_excess_bad_len: assert property (@(posedge clk) disable iff (!rst_n)
    out_vld_r && frame_end_r && byte_class_r == lpfp_pkg::CLS_EXCESS
    |-> frame_status_r == lpfp_pkg::ST_LEN_BAD)
    else $error("frame ending in excess bytes not flagged");

  // state is back at reset value after a closing item moves on
  a_clear_after_end: assert property (@(posedge clk) disable iff (!rst_n)
    adv && in_last_r |=> byte_count_r == '0 && id_len_r == 8'd0 && pay_len_r == 8'd0)
    else $error("frame state not cleared after last byte");
`endif

endmodule
